// ----- rtl/sprm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprm_pkg
// Shared constants, types and rounding functions of the seek point
// rounding merger.
// ----------------------------------------------------------------------------
package sprm_pkg;

   localparam int VALUE_WIDTH     = 62;
   localparam int POINT_WIDTH     = VALUE_WIDTH + 1;
   localparam int ROUND_WIDTH     = 6;
   localparam int MAX_ROUND_BITS  = VALUE_WIDTH - 1;
   localparam int REQ_DATA_WIDTH  = ((2 * VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH  = ((2 * POINT_WIDTH + 7) / 8) * 8;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_ROUND  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECOND_ROUND = CSR_INDEX_WIDTH'(1);

   typedef struct packed {
      logic [POINT_WIDTH-1:0] first;
      logic [POINT_WIDTH-1:0] second;
      logic                   fin;
   } point_type;

   // one or two seek points produced by one input transfer
   typedef struct packed {
      point_type p0;
      point_type p1;
      logic      pair;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } slot_type;

   function automatic logic [POINT_WIDTH-1:0] low_ones(input logic [ROUND_WIDTH-1:0] bits);
      logic [ROUND_WIDTH-1:0] sat;
      sat = (bits > ROUND_WIDTH'(MAX_ROUND_BITS)) ? ROUND_WIDTH'(MAX_ROUND_BITS) : bits;
      return (POINT_WIDTH'(1) << sat) - POINT_WIDTH'(1);
   endfunction

   function automatic logic [POINT_WIDTH-1:0] round_down(input logic [POINT_WIDTH-1:0] v,
                                                         input logic [ROUND_WIDTH-1:0] bits);
      return v & ~low_ones(bits);
   endfunction

   // values stay below 2^62, so the sum cannot leave the point width
   function automatic logic [POINT_WIDTH-1:0] round_up(input logic [POINT_WIDTH-1:0] v,
                                                       input logic [ROUND_WIDTH-1:0] bits);
      logic [POINT_WIDTH-1:0] ones;
      ones = low_ones(bits);
      return (v + ones) & ~ones;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/seek_point_rounding_merger.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// seek_point_rounding_merger
// Rounds runs of nondecreasing value pairs and merges them into seek points.
// ----------------------------------------------------------------------------
// One value pair is taken per clock cycle while the command queue is not full.
// A pair that emits at most one seek point keeps that rate; the last pair of
// a longer run emits the held point and the final point, which pass one after
// the other through the single result register. Rounding, comparison against
// the held point and the decision are done in the cycle a pair is taken; the
// point reaches rsp_ via the command queue and the result register when the
// result side is free. A two-entry command queue lets the input side go on
// while results wait. Configuration writes take effect on the next cycle.
// ----------------------------------------------------------------------------
module seek_point_rounding_merger (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // first_value, second_value, zero fill
   input  wire logic [sprm_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // end_of_run
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // rounded_first, rounded_second, zero fill
   output logic [sprm_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // final_point
   output logic                                      rsp_tlast,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sprm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sprm_pkg::ROUND_WIDTH-1:0]     csr_write_data
);
   import sprm_pkg::*;

   slot_type push;
   slot_type head;
   logic     queue_full;
   logic     pop;

   sprm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push)
   );

   sprm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   sprm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- rtl/sprm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprm_front
// Accepts value pairs, rounds them, tracks the held seek point and turns
// each transfer into a command of zero, one or two seek points.
// ----------------------------------------------------------------------------
module sprm_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // first_value, second_value, zero fill
   input  wire logic [sprm_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // end_of_run
   input  wire logic                                 req_tlast,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sprm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sprm_pkg::ROUND_WIDTH-1:0]     csr_write_data,
   input  wire logic                                 queue_full,
   output sprm_pkg::slot_type                        push
);
   import sprm_pkg::*;

   logic [ROUND_WIDTH-1:0] first_bits_ff, first_bits_in;
   logic [ROUND_WIDTH-1:0] second_bits_ff, second_bits_in;
   logic                   run_start_ff, run_start_in;
   logic [POINT_WIDTH-1:0] held_first_ff, held_first_in;
   logic [POINT_WIDTH-1:0] held_second_ff, held_second_in;

   logic                   accept;
   logic [POINT_WIDTH-1:0] f_value, s_value;
   logic [POINT_WIDTH-1:0] f_down, s_down, f_up, s_up;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign f_value    = {1'b0, req_tdata[VALUE_WIDTH-1:0]};
   assign s_value    = {1'b0, req_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]};
   assign f_down     = round_down(f_value, first_bits_ff);
   assign s_down     = round_down(s_value, second_bits_ff);
   assign f_up       = round_up(f_value, first_bits_ff);
   assign s_up       = round_up(s_value, second_bits_ff);

   always_comb begin
      first_bits_in  = first_bits_ff;
      second_bits_in = second_bits_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FIRST_ROUND:  first_bits_in  = csr_write_data;
            CSR_SECOND_ROUND: second_bits_in = csr_write_data;
            default:          first_bits_in  = first_bits_ff;
         endcase
      end
   end

   always_comb begin
      run_start_in   = run_start_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      push.valid     = 1'b0;
      push.cmd.pair  = 1'b0;
      push.cmd.p0    = '{first: held_first_ff, second: held_second_ff, fin: 1'b0};
      push.cmd.p1    = '{first: f_up, second: s_up, fin: 1'b1};
      if (accept) begin
         if (run_start_ff) begin
            if (req_tlast) begin
               // single-pair run: only its rounded-down point
               push.valid  = 1'b1;
               push.cmd.p0 = '{first: f_down, second: s_down, fin: 1'b1};
            end else begin
               held_first_in  = f_down;
               held_second_in = s_down;
               run_start_in   = 1'b0;
            end
         end else if (req_tlast) begin
            push.valid    = 1'b1;
            push.cmd.pair = 1'b1;
            run_start_in  = 1'b1;
         end else if (f_down > held_first_ff) begin
            held_first_in = f_down;
            if (s_up > held_second_ff) begin
               push.valid     = 1'b1;
               held_second_in = s_up;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_bits_ff  <= '0;
         second_bits_ff <= '0;
         run_start_ff   <= 1'b1;
         held_first_ff  <= '0;
         held_second_ff <= '0;
      end else begin
         first_bits_ff  <= first_bits_in;
         second_bits_ff <= second_bits_in;
         run_start_ff   <= run_start_in;
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
      end
   end

   // a closing pair always re-arms the run
   assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> run_start_ff)
      else $error("run not restarted after last pair");

endmodule
`default_nettype wire

// ----- rtl/sprm_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprm_queue
// Short command queue between the classifying front and the output back.
// ----------------------------------------------------------------------------
module sprm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sprm_pkg::slot_type push,
   input  wire logic               pop,
   output logic                    full,
   output sprm_pkg::slot_type      head
);
   import sprm_pkg::*;

   cmd_type                    slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign head       = '{valid: (count_ff != '0), cmd: slots_ff[rd_ptr_ff]};
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("command pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from an empty queue");

endmodule
`default_nettype wire

// ----- rtl/sprm_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprm_back
// Unpacks queued commands into seek points, one per cycle while the receiver
// is ready, through the result register.
// ----------------------------------------------------------------------------
module sprm_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sprm_pkg::slot_type                  head,
   output logic                                     pop,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // rounded_first, rounded_second, zero fill
   output logic [sprm_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   // final_point
   output logic                                     rsp_tlast
);
   import sprm_pkg::*;

   logic      rsp_valid_ff, rsp_valid_in;
   point_type point_ff, point_in;
   logic      half_ff, half_in;
   logic      load;

   assign load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      point_in     = point_ff;
      half_in      = half_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head.valid;
         if (head.valid) begin
            point_in = half_ff ? head.cmd.p1 : head.cmd.p0;
            pop      = half_ff || !head.cmd.pair;
            half_in  = !pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({point_ff.second, point_ff.first});
   assign rsp_tlast  = point_ff.fin;

   // the second half is only ever pending on a two-point command
   assert property (@(posedge clock) disable iff (reset)
      half_ff |-> head.valid && head.cmd.pair)
      else $error("second point pending without a paired command");

endmodule
`default_nettype wire

// ----- tb/tb_seek_point_rounding_merger.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seek_point_rounding_merger
// Drives runs of value pairs into the seek point rounding merger with random
// gaps on both stream sides. Every accepted pair updates a cycle-free model
// of the held point, and each seek point that comes out is compared with the
// oldest point that model has predicted. The rounding registers are changed
// between phases, including their extremes and the saturating codes.
// ----------------------------------------------------------------------------
module tb_seek_point_rounding_merger;
   import sprm_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] MAX_VALUE = '1;

   // --------------------------------------------------------------------------
   // predicted seek points and the held pair that decides them
   // --------------------------------------------------------------------------
   class seek_point_tracker;
      logic [ROUND_WIDTH-1:0] first_bits;
      logic [ROUND_WIDTH-1:0] second_bits;
      bit                     awaiting_start;
      logic [POINT_WIDTH-1:0] held_first;
      logic [POINT_WIDTH-1:0] held_second;
      point_type              expected_points[$];
      int                     errors;
      int                     points_checked;
      int                     pairs_taken;
      int                     runs_closed;

      function new();
         first_bits     = '0;
         second_bits    = '0;
         awaiting_start = 1'b1;
         held_first     = '0;
         held_second    = '0;
         errors         = 0;
         points_checked = 0;
         pairs_taken    = 0;
         runs_closed    = 0;
      endfunction

      function void configure(logic [CSR_INDEX_WIDTH-1:0] index, logic [ROUND_WIDTH-1:0] value);
         if (index == CSR_FIRST_ROUND)
            first_bits = value;
         else
            second_bits = value;
      endfunction

      function logic [POINT_WIDTH-1:0] ones_below(logic [ROUND_WIDTH-1:0] bits);
         int n;
         n = (bits > MAX_ROUND_BITS) ? MAX_ROUND_BITS : int'(bits);
         return (POINT_WIDTH'(1) << n) - POINT_WIDTH'(1);
      endfunction

      function logic [POINT_WIDTH-1:0] floor_to(logic [POINT_WIDTH-1:0] v,
                                                logic [ROUND_WIDTH-1:0] bits);
         return v & ~ones_below(bits);
      endfunction

      function logic [POINT_WIDTH-1:0] ceil_to(logic [POINT_WIDTH-1:0] v,
                                               logic [ROUND_WIDTH-1:0] bits);
         logic [POINT_WIDTH-1:0] ones;
         ones = ones_below(bits);
         return (v + ones) & ~ones;
      endfunction

      function void push_point(logic [POINT_WIDTH-1:0] f, logic [POINT_WIDTH-1:0] s,
                               logic fin);
         point_type p;
         p.first  = f;
         p.second = s;
         p.fin    = fin;
         expected_points.insert(expected_points.size(), p);
      endfunction

      function void take_pair(logic [VALUE_WIDTH-1:0] f, logic [VALUE_WIDTH-1:0] s,
                              logic end_of_run);
         logic [POINT_WIDTH-1:0] wf;
         logic [POINT_WIDTH-1:0] ws;
         logic [POINT_WIDTH-1:0] r1;
         logic [POINT_WIDTH-1:0] r2;
         wf = POINT_WIDTH'(f);
         ws = POINT_WIDTH'(s);
         pairs_taken++;
         if (end_of_run)
            runs_closed++;
         if (awaiting_start) begin
            r1 = floor_to(wf, first_bits);
            r2 = floor_to(ws, second_bits);
            if (end_of_run) begin
               push_point(r1, r2, 1'b1);
            end else begin
               held_first     = r1;
               held_second    = r2;
               awaiting_start = 1'b0;
            end
         end else if (end_of_run) begin
            push_point(held_first, held_second, 1'b0);
            push_point(ceil_to(wf, first_bits), ceil_to(ws, second_bits), 1'b1);
            awaiting_start = 1'b1;
         end else begin
            r1 = floor_to(wf, first_bits);
            r2 = ceil_to(ws, second_bits);
            if (r1 > held_first) begin
               if (r2 > held_second) begin
                  push_point(held_first, held_second, 1'b0);
                  held_second = r2;
               end
               held_first = r1;
            end
         end
      endfunction

      function void check_point(logic [POINT_WIDTH-1:0] f, logic [POINT_WIDTH-1:0] s,
                                logic fin);
         point_type want;
         if (expected_points.size() == 0) begin
            $error("unexpected seek point first=%h second=%h final=%b", f, s, fin);
            errors++;
            return;
         end
         want = expected_points.pop_front();
         points_checked++;
         if (f !== want.first) begin
            $error("rounded_first: expected %h, got %h", want.first, f);
            errors++;
         end
         if (s !== want.second) begin
            $error("rounded_second: expected %h, got %h", want.second, s);
            errors++;
         end
         if (fin !== want.fin) begin
            $error("final_point: expected %b, got %b", want.fin, fin);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                       req_tlast = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_FIRST_ROUND;
   logic [ROUND_WIDTH-1:0]     csr_write_data = '0;

   seek_point_tracker tracker = new();
   bit                idle_on = 1'b1;
   int                settings_used = 0;

   seek_point_rounding_merger dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_seek_point_rounding_merger failed");
      $finish;
   end

   // result side: check each transfer, then choose the next ready
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            tracker.check_point(rsp_tdata[POINT_WIDTH-1:0],
                                rsp_tdata[2*POINT_WIDTH-1:POINT_WIDTH], rsp_tlast);
         rsp_tready <= !(idle_on && $urandom_range(99) < 17);
      end
   end

   task automatic send_pair(input logic [VALUE_WIDTH-1:0] f, input logic [VALUE_WIDTH-1:0] s,
                            input logic end_of_run);
      while (idle_on && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_WIDTH'({s, f});
      req_tlast  <= end_of_run;
      do
         @(posedge clock);
      while (!req_tready);
      tracker.take_pair(f, s, end_of_run);
   endtask

   // hold off the sender until every predicted point has come out
   task automatic wait_for_points();
      req_tvalid <= 1'b0;
      while (tracker.expected_points.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_rounding(input logic [ROUND_WIDTH-1:0] first_bits,
                                 input logic [ROUND_WIDTH-1:0] second_bits);
      wait_for_points();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FIRST_ROUND;
      csr_write_data   <= first_bits;
      @(posedge clock);
      tracker.configure(CSR_FIRST_ROUND, first_bits);
      csr_index        <= CSR_SECOND_ROUND;
      csr_write_data   <= second_bits;
      @(posedge clock);
      tracker.configure(CSR_SECOND_ROUND, second_bits);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v & 64'(MAX_VALUE);
   endfunction

   // nondecreasing step, scaled near the rounding granule
   function automatic logic [63:0] step_up(logic [63:0] v, int granule);
      int shift;
      shift = $urandom_range(0, (granule + 2 > 61) ? 61 : granule + 2);
      v = v + (64'($urandom_range(0, 3)) << shift);
      return (v > 64'(MAX_VALUE)) ? 64'(MAX_VALUE) : v;
   endfunction

   task automatic send_random_run(input int granule);
      int          len;
      logic [63:0] f;
      logic [63:0] s;
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
      f   = random_value() >> $urandom_range(0, 61);
      s   = random_value() >> $urandom_range(0, 61);
      for (int i = 0; i < len; i++) begin
         // a few stray pairs break the ordering
         if ($urandom_range(99) < 8)
            send_pair(VALUE_WIDTH'(random_value()), VALUE_WIDTH'(random_value()),
                      i == len - 1);
         else
            send_pair(f[VALUE_WIDTH-1:0], s[VALUE_WIDTH-1:0], i == len - 1);
         f = step_up(f, granule);
         s = step_up(s, granule);
      end
   endtask

   initial begin
      logic [ROUND_WIDTH-1:0] fb;
      logic [ROUND_WIDTH-1:0] sb;
      int                     phase_pairs;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset rounding: no bits cleared
      send_pair('0, '0, 1'b1);
      send_pair(MAX_VALUE, MAX_VALUE, 1'b1);
      send_pair(62'd5, 62'd7, 1'b0);
      send_pair(62'd5, 62'd9, 1'b0);
      send_pair(62'd6, 62'd7, 1'b0);
      send_pair(62'd7, 62'd3, 1'b0);
      send_pair(62'd8, 62'd10, 1'b0);
      send_pair(MAX_VALUE, MAX_VALUE, 1'b1);
      send_pair(62'd10, 62'd10, 1'b0);
      send_pair(62'd10, 62'd10, 1'b1);

      write_rounding(6'd4, 6'd3);
      send_pair(62'h13, 62'h17, 1'b0);
      send_pair(62'h1f, 62'h18, 1'b0);
      send_pair(62'h20, 62'h19, 1'b0);
      send_pair(62'h25, 62'h1f, 1'b1);

      write_rounding(6'd61, 6'd61);
      send_pair(MAX_VALUE, MAX_VALUE, 1'b1);
      send_pair(62'd1, 62'd1, 1'b0);
      send_pair(62'h2000_0000_0000_0000, 62'h2000_0000_0000_0001, 1'b0);
      send_pair(MAX_VALUE, MAX_VALUE, 1'b1);

      // codes above the limit saturate
      write_rounding(6'd63, 6'd62);
      send_pair(MAX_VALUE, '0, 1'b1);
      send_pair('0, MAX_VALUE, 1'b0);
      send_pair(MAX_VALUE, MAX_VALUE, 1'b1);

      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin
               fb = 6'd0;
               sb = 6'd61;
            end
            1: begin
               fb = 6'd61;
               sb = 6'd0;
            end
            2: begin
               fb = 6'd0;
               sb = 6'd0;
            end
            3: begin
               fb = 6'd62;
               sb = 6'd63;
            end
            default: begin
               fb = ($urandom_range(3) == 0) ? ROUND_WIDTH'($urandom_range(0, 63)) :
                                               ROUND_WIDTH'($urandom_range(0, 12));
               sb = ($urandom_range(3) == 0) ? ROUND_WIDTH'($urandom_range(0, 63)) :
                                               ROUND_WIDTH'($urandom_range(0, 12));
            end
         endcase
         write_rounding(fb, sb);
         idle_on     = (phase != 4);
         phase_pairs = tracker.pairs_taken;
         while (tracker.pairs_taken - phase_pairs < 136) begin
            send_random_run((fb > sb) ? int'(fb) : int'(sb));
            if (phase == 6 && tracker.pairs_taken - phase_pairs >= 68 &&
                tracker.pairs_taken - phase_pairs < 84)
               wait_for_points();
         end
      end

      idle_on = 1'b1;
      wait_for_points();
      repeat (10) @(posedge clock);

      $display("covered %0d pairs in %0d runs under %0d rounding settings",
               tracker.pairs_taken, tracker.runs_closed, settings_used + 1);
      $display("%0d seek points compared, %0d mismatches",
               tracker.points_checked, tracker.errors);
      if (tracker.errors == 0)
         $display("tb_seek_point_rounding_merger passed");
      else
         $display("tb_seek_point_rounding_merger failed");
      $finish;
   end

endmodule
